### sv/assert_macros.svh
// Assertion macros shared by the address generator modules.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMAAG_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMAAG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/dmaag_pkg.sv
// Shared types, register offsets and helper functions of the DMA address generator.
// Used by the front end, the back end, the top level and the testbench; depends on nothing.
`default_nettype none

package dmaag_pkg;

   localparam int DEF_NUM_CHANNELS      = 8;
   localparam int DEF_BYTES_PER_CHANNEL = 16;

   // Widths of the queue fields, sized for the largest configuration.
   localparam int CHAN_W = 3;
   localparam int OFS_W  = 4;

   // Byte offsets of the channel registers.
   localparam int OFS_PARAMS   = 0;
   localparam int OFS_BASE     = 1;
   localparam int OFS_ADDR_LO  = 2;
   localparam int OFS_ADDR_HI  = 3;
   localparam int OFS_BANK     = 4;
   localparam int OFS_COUNT_LO = 5;
   localparam int OFS_COUNT_HI = 6;

   // Address step codes held in bits 4:3 of the params register.
   localparam logic [1:0] STEP_INC = 2'b00;
   localparam logic [1:0] STEP_DEC = 2'b10;

   // Pattern mode codes held in bits 2:0 of the params register.
   localparam logic [2:0] PAT_SINGLE      = 3'd0;
   localparam logic [2:0] PAT_ALT         = 3'd1;
   localparam logic [2:0] PAT_DOUBLE      = 3'd2;
   localparam logic [2:0] PAT_PAIRS       = 3'd3;
   localparam logic [2:0] PAT_QUAD        = 3'd4;
   localparam logic [2:0] PAT_ALT_B       = 3'd5;
   localparam logic [2:0] PAT_DOUBLE_B    = 3'd6;
   localparam logic [2:0] PAT_PAIRS_B     = 3'd7;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2,
      OP_TICK  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type        op;
      logic              in_range;
      logic [CHAN_W-1:0] chan;
      logic [OFS_W-1:0]  offset;
      logic [7:0]        wdata;
      logic [7:0]        mask;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        xfer_valid;
      logic [23:0] a_bus_address;
      logic [7:0]  b_bus_address;
      logic        to_memory;
      logic [2:0]  channel_number;
      logic        channel_last;
      logic        all_done;
   } result_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [2:0] lowest_set(input logic [7:0] m);
      logic [2:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         if (m[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

   // B-bus offset for a pattern mode at a given step of the pattern.
   function automatic logic [1:0] pattern_offset(input logic [2:0] mode,
                                                 input logic [1:0] step);
      logic [1:0] r;
      unique case (mode)
         PAT_SINGLE, PAT_DOUBLE, PAT_DOUBLE_B: r = 2'd0;
         PAT_ALT, PAT_ALT_B:                   r = {1'b0, step[0]};
         PAT_PAIRS, PAT_PAIRS_B:               r = {1'b0, step[1]};
         PAT_QUAD:                             r = step;
         default:                              r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/dmaag_ifs.sv
// Valid/ready channel interfaces for the request and response sides of the block.
// Depends on nothing; field widths are fixed by the transaction format.
`default_nettype none

interface dmaag_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] reg_addr;
   logic [7:0] write_data;
   logic [7:0] channel_mask;

   modport source (output valid, output opcode, output reg_addr, output write_data,
                   output channel_mask, input ready);
   modport sink   (input valid, input opcode, input reg_addr, input write_data,
                   input channel_mask, output ready);
endinterface

interface dmaag_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        xfer_valid;
   logic [23:0] a_bus_address;
   logic [7:0]  b_bus_address;
   logic        to_memory;
   logic [2:0]  channel_number;
   logic        channel_last;
   logic        all_done;

   modport source (output valid, output read_data, output xfer_valid, output a_bus_address,
                   output b_bus_address, output to_memory, output channel_number,
                   output channel_last, output all_done, input ready);
   modport sink   (input valid, input read_data, input xfer_valid, input a_bus_address,
                   input b_bus_address, input to_memory, input channel_number,
                   input channel_last, input all_done, output ready);
endinterface

`default_nettype wire

### sv/general_dma_address_generator.sv
// DMA address generator top level: decode front end, two-entry queue, execute back end.
// A response passes through the queue, the bank read and the result register.
// Throughput: one transaction per cycle sustained while the response side does not stall.
// Register writes and channel starts give no response; reads and ticks give exactly one.
// Reset clears the queue, stage valids and channel state at once; the register banks hold
// undefined data until written and get no clearing pass. Uses dmaag_pkg and dmaag_ifs.
`default_nettype none

module general_dma_address_generator #(
   parameter int NUM_CHANNELS      = dmaag_pkg::DEF_NUM_CHANNELS,
   parameter int BYTES_PER_CHANNEL = dmaag_pkg::DEF_BYTES_PER_CHANNEL
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dmaag_req_if.sink   req_bus,
   dmaag_rsp_if.source rsp_bus
);

   dmaag_pkg::queue_head_type head;
   logic                      pop;

   dmaag_front #(
      .NUM_CHANNELS      (NUM_CHANNELS),
      .BYTES_PER_CHANNEL (BYTES_PER_CHANNEL)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .head    (head),
      .pop     (pop)
   );

   dmaag_back #(
      .NUM_CHANNELS      (NUM_CHANNELS),
      .BYTES_PER_CHANNEL (BYTES_PER_CHANNEL)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

### sv/dmaag_ram.sv
// Generic single-write, single-read RAM with a registered, write-first read port.
// Depends on nothing.
`default_nettype none

module dmaag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  write_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]                      write_data,
   input  wire logic                                  read_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic      [WIDTH-1:0]                      read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      // A read of the word being written returns the new data.
      if (read_en) begin
         if (write_en && (write_addr == read_addr)) begin
            read_data <= write_data;
         end else begin
            read_data <= mem[read_addr];
         end
      end
   end

endmodule

`default_nettype wire

### sv/dmaag_front.sv
// Front end: accepts request transactions, splits the register address into channel
// and offset, and holds decoded items in a two-entry queue. Uses dmaag_pkg.
`default_nettype none
`include "assert_macros.svh"

module dmaag_front #(
   parameter int NUM_CHANNELS      = dmaag_pkg::DEF_NUM_CHANNELS,
   parameter int BYTES_PER_CHANNEL = dmaag_pkg::DEF_BYTES_PER_CHANNEL
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dmaag_req_if.sink                 req_bus,
   output dmaag_pkg::queue_head_type head,
   input  wire logic                 pop
);

   localparam int CW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int OW        = $clog2(BYTES_PER_CHANNEL);
   localparam int REG_BYTES = NUM_CHANNELS * BYTES_PER_CHANNEL;

   dmaag_pkg::item_type item;
   dmaag_pkg::item_type queue_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push;
   logic [CW-1:0]       chan;
   logic [7:0]          ofs;

   // Channel and offset by comparing against each channel's base address.
   always_comb begin
      chan = '0;
      ofs  = req_bus.reg_addr;
      for (int c = 1; c < NUM_CHANNELS; c++) begin
         if (req_bus.reg_addr >= 8'(c * BYTES_PER_CHANNEL)) begin
            chan = CW'(c);
            ofs  = req_bus.reg_addr - 8'(c * BYTES_PER_CHANNEL);
         end
      end
   end

   always_comb begin
      item              = '0;
      item.op           = dmaag_pkg::opcode_type'(req_bus.opcode);
      item.in_range     = ({1'b0, req_bus.reg_addr} < 9'(REG_BYTES));
      item.chan[CW-1:0] = chan;
      item.offset[OW-1:0] = ofs[OW-1:0];
      item.wdata        = req_bus.write_data;
      item.mask         = req_bus.channel_mask;
   end

   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = queue_ff[rd_ptr_ff];

   `DMAAG_ASSERT_NEXT(a_queue_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1, "queue count did not grow on a lone push")
   `DMAAG_ASSERT_NEXT(a_queue_drain, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1, "queue count did not shrink on a lone pop")

endmodule

`default_nettype wire

### sv/dmaag_back.sv
// Back end: executes queued items against the per-offset register banks, steps the
// active channel and registers the response. Uses dmaag_pkg and dmaag_ram.
`default_nettype none
`include "assert_macros.svh"

module dmaag_back #(
   parameter int NUM_CHANNELS      = dmaag_pkg::DEF_NUM_CHANNELS,
   parameter int BYTES_PER_CHANNEL = dmaag_pkg::DEF_BYTES_PER_CHANNEL
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dmaag_pkg::queue_head_type head,
   output logic                      pop,
   dmaag_rsp_if.source               rsp_bus
);

   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int OW = $clog2(BYTES_PER_CHANNEL);

   // Execute stage: the item whose bank read data is now available.
   logic                  x2_valid_ff, x2_valid_in;
   dmaag_pkg::item_type   x2_item_ff;
   logic [CW-1:0]         x2_ch_ff, x1_ch;

   // Channel engine state.
   logic [NUM_CHANNELS-1:0] pending_ff, pending_in;
   logic                    active_ff, active_in;
   logic [CW-1:0]           cur_ff, cur_in;
   logic [15:0]             waddr_ff, waddr_in;
   logic [15:0]             wcount_ff, wcount_in;
   logic [1:0]              pstep_ff, pstep_in;

   dmaag_pkg::result_type out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;

   logic [7:0]  bank_q [BYTES_PER_CHANNEL];
   logic        is_read, is_write, is_start, is_tick;
   logic        take, xfer, last, has_rsp, x2_adv;
   logic [7:0]  params, base, bank;
   logic [15:0] addr_cur, addr_next, cnt_cur, inc;
   logic [1:0]  step_cur;
   logic [2:0]  low_pick;

   always_comb begin
      is_read  = x2_valid_ff && (x2_item_ff.op == dmaag_pkg::OP_READ);
      is_write = x2_valid_ff && (x2_item_ff.op == dmaag_pkg::OP_WRITE);
      is_start = x2_valid_ff && (x2_item_ff.op == dmaag_pkg::OP_START);
      is_tick  = x2_valid_ff && (x2_item_ff.op == dmaag_pkg::OP_TICK);

      params = bank_q[dmaag_pkg::OFS_PARAMS];
      base   = bank_q[dmaag_pkg::OFS_BASE];
      bank   = bank_q[dmaag_pkg::OFS_BANK];

      // A tick with no channel in progress takes the channel read for it.
      take     = !active_ff;
      xfer     = is_tick && (active_ff || (pending_ff != '0));
      addr_cur = take ? {bank_q[dmaag_pkg::OFS_ADDR_HI], bank_q[dmaag_pkg::OFS_ADDR_LO]}
                      : waddr_ff;
      cnt_cur  = take ? {bank_q[dmaag_pkg::OFS_COUNT_HI], bank_q[dmaag_pkg::OFS_COUNT_LO]}
                      : wcount_ff;
      step_cur = take ? 2'd0 : pstep_ff;
      last     = (cnt_cur == 16'd1);

      unique case (params[4:3])
         dmaag_pkg::STEP_INC: inc = 16'd1;
         dmaag_pkg::STEP_DEC: inc = 16'hFFFF;
         default:             inc = 16'd0;
      endcase
      addr_next = addr_cur + inc;
   end

   // State after the item in the execute stage; equals the current state when empty.
   always_comb begin
      pending_in = pending_ff;
      active_in  = active_ff;
      cur_in     = cur_ff;
      waddr_in   = waddr_ff;
      wcount_in  = wcount_ff;
      pstep_in   = pstep_ff;
      if (is_start) begin
         pending_in = pending_ff | x2_item_ff.mask[NUM_CHANNELS-1:0];
      end
      if (xfer) begin
         active_in = !last;
         cur_in    = x2_ch_ff;
         waddr_in  = addr_next;
         wcount_in = cnt_cur - 16'd1;
         pstep_in  = step_cur + 2'd1;
         if (last) begin
            pending_in[x2_ch_ff] = 1'b0;
         end
      end
   end

   always_comb begin
      out_in          = '0;
      out_in.all_done = (pending_in == '0) && !active_in;
      if (is_read && x2_item_ff.in_range) begin
         out_in.read_data = bank_q[x2_item_ff.offset[OW-1:0]];
      end
      if (xfer) begin
         out_in.xfer_valid    = 1'b1;
         out_in.a_bus_address = {bank, addr_cur};
         out_in.b_bus_address = base + {6'd0, dmaag_pkg::pattern_offset(params[2:0], step_cur)};
         out_in.to_memory     = params[7];
         out_in.channel_number[CW-1:0] = x2_ch_ff;
         out_in.channel_last  = last;
      end
   end

   always_comb begin
      has_rsp      = is_read || is_tick;
      x2_adv       = x2_valid_ff && (!has_rsp || !out_valid_ff || rsp_bus.ready);
      pop          = head.valid && (!x2_valid_ff || x2_adv);
      x2_valid_in  = pop || (x2_valid_ff && !x2_adv);
      out_valid_in = (x2_adv && has_rsp) || (out_valid_ff && !rsp_bus.ready);
      // The bank read address follows the state that the executing item leaves behind.
      low_pick     = dmaag_pkg::lowest_set(8'(pending_in));
      if (head.item.op == dmaag_pkg::OP_TICK) begin
         x1_ch = active_in ? cur_in : low_pick[CW-1:0];
      end else begin
         x1_ch = head.item.chan[CW-1:0];
      end
   end

   for (genvar o = 0; o < BYTES_PER_CHANNEL; o++) begin : g_bank
      logic       we;
      logic [7:0] wd;

      always_comb begin
         we = 1'b0;
         wd = x2_item_ff.wdata;
         if (x2_adv) begin
            if (is_write && x2_item_ff.in_range && (x2_item_ff.offset[OW-1:0] == OW'(o))) begin
               we = 1'b1;
            end
            // A finished channel gets its stepped address back and a cleared count.
            if (xfer && last) begin
               if (o == dmaag_pkg::OFS_ADDR_LO) begin
                  we = 1'b1;
                  wd = addr_next[7:0];
               end
               if (o == dmaag_pkg::OFS_ADDR_HI) begin
                  we = 1'b1;
                  wd = addr_next[15:8];
               end
               if ((o == dmaag_pkg::OFS_COUNT_LO) || (o == dmaag_pkg::OFS_COUNT_HI)) begin
                  we = 1'b1;
                  wd = 8'd0;
               end
            end
         end
      end

      dmaag_ram #(
         .WIDTH (8),
         .DEPTH (NUM_CHANNELS)
      ) u_bank (
         .clock      (clock),
         .write_en   (we),
         .write_addr (x2_ch_ff),
         .write_data (wd),
         .read_en    (pop),
         .read_addr  (x1_ch),
         .read_data  (bank_q[o])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= '0;
         active_ff    <= 1'b0;
         cur_ff       <= '0;
         waddr_ff     <= '0;
         wcount_ff    <= '0;
         pstep_ff     <= '0;
      end else begin
         x2_valid_ff  <= x2_valid_in;
         out_valid_ff <= out_valid_in;
         if (x2_adv) begin
            pending_ff <= pending_in;
            active_ff  <= active_in;
            cur_ff     <= cur_in;
            waddr_ff   <= waddr_in;
            wcount_ff  <= wcount_in;
            pstep_ff   <= pstep_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x2_item_ff <= head.item;
         x2_ch_ff   <= x1_ch;
      end
      if (x2_adv && has_rsp) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.read_data      = out_ff.read_data;
   assign rsp_bus.xfer_valid     = out_ff.xfer_valid;
   assign rsp_bus.a_bus_address  = out_ff.a_bus_address;
   assign rsp_bus.b_bus_address  = out_ff.b_bus_address;
   assign rsp_bus.to_memory      = out_ff.to_memory;
   assign rsp_bus.channel_number = out_ff.channel_number;
   assign rsp_bus.channel_last   = out_ff.channel_last;
   assign rsp_bus.all_done       = out_ff.all_done;

   `DMAAG_ASSERT_SAME(a_take_lowest, clock, reset,
      is_tick && !active_ff && (pending_ff != '0),
      x2_ch_ff == CW'(dmaag_pkg::lowest_set(8'(pending_ff))),
      "tick took a channel other than the lowest pending one")
   `DMAAG_ASSERT_SAME(a_active_pending, clock, reset, active_ff, pending_ff[cur_ff],
      "channel in progress is not marked pending")
   `DMAAG_ASSERT_SAME(a_pop_room, clock, reset, pop, !x2_valid_ff || x2_adv,
      "queue popped while the execute stage was held")

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of general_dma_address_generator: a directed table, then random
// channel programs and transfer ticks, each response checked against a behavioral predictor
// or a row's expected result. Depends on dmaag_pkg, the dmaag_ifs channel interfaces and the block's RTL.

module testbench;
   import dmaag_pkg::*;

   localparam int NUM_CH    = DEF_NUM_CHANNELS;
   localparam int REG_BYTES = DEF_NUM_CHANNELS * DEF_BYTES_PER_CHANNEL;
   localparam int RANDOM_ITEMS = 1050;
   localparam int LIMIT_NS  = 100_000_000;
   // B-bus offset sequences, two bits per step, one byte per pattern mode (mode 7 on top).
   localparam logic [63:0] PAT_SEQ = 64'h50_00_44_E4_50_00_44_00;

   typedef struct {
      opcode_type  op;
      logic [7:0]  addr;
      logic [7:0]  data;
      logic [7:0]  mask;
      int unsigned reps;
      bit          typed;
      result_type  want;
   } stim_row_type;

   logic clock;
   logic reset;

   dmaag_req_if req_bus();
   dmaag_rsp_if rsp_bus();

   general_dma_address_generator dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Predictor state.
   logic [7:0]  chan_regs [REG_BYTES];
   logic [7:0]  pend_chans;
   bit          xfer_busy;
   logic [2:0]  xfer_chan;
   logic [15:0] xfer_addr;
   logic [15:0] xfer_left;
   logic [1:0]  pat_phase;

   result_type   due_responses[$];
   stim_row_type directed_rows[$];
   int unsigned items_sent;
   int unsigned responses_seen;
   int unsigned mismatches;
   int unsigned gap_pct;
   bit          steady;
   bit          pressure_done;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic predict_dma(input opcode_type op, input logic [7:0] addr, data, mask,
                              output bit produces, output result_type r);
      logic [7:0]  params;
      logic [15:0] step;
      r = '0;
      produces = 1'b0;
      case (op)
         OP_READ: begin
            produces = 1'b1;
            if (addr < REG_BYTES) r.read_data = chan_regs[addr[6:0]];
            r.all_done = (pend_chans == '0) && !xfer_busy;
         end
         OP_WRITE: begin
            if (addr < REG_BYTES) chan_regs[addr[6:0]] = data;
         end
         OP_START: begin
            pend_chans |= mask;
         end
         OP_TICK: begin
            produces = 1'b1;
            if (!xfer_busy && pend_chans == '0) begin
               r.all_done = 1'b1;
            end else begin
               if (!xfer_busy) begin
                  // Take the lowest pending channel; its address and count are latched here.
                  for (int c = NUM_CH - 1; c >= 0; c--) begin
                     if (pend_chans[c]) xfer_chan = 3'(c);
                  end
                  xfer_addr = {chan_regs[{xfer_chan, 4'(OFS_ADDR_HI)}],
                               chan_regs[{xfer_chan, 4'(OFS_ADDR_LO)}]};
                  xfer_left = {chan_regs[{xfer_chan, 4'(OFS_COUNT_HI)}],
                               chan_regs[{xfer_chan, 4'(OFS_COUNT_LO)}]};
                  pat_phase = '0;
                  xfer_busy = 1'b1;
               end
               params = chan_regs[{xfer_chan, 4'(OFS_PARAMS)}];
               case (params[4:3])
                  STEP_INC: step = 16'h0001;
                  STEP_DEC: step = 16'hFFFF;
                  default:  step = 16'h0000;
               endcase
               r.xfer_valid     = 1'b1;
               r.a_bus_address  = {chan_regs[{xfer_chan, 4'(OFS_BANK)}], xfer_addr};
               r.b_bus_address  = chan_regs[{xfer_chan, 4'(OFS_BASE)}]
                                  + 8'(PAT_SEQ[{params[2:0], pat_phase, 1'b0} +: 2]);
               r.to_memory      = params[7];
               r.channel_number = xfer_chan;
               r.channel_last   = (xfer_left == 16'd1);
               xfer_addr += step;
               xfer_left -= 16'd1;
               pat_phase += 2'd1;
               if (r.channel_last) begin
                  chan_regs[{xfer_chan, 4'(OFS_ADDR_LO)}]  = xfer_addr[7:0];
                  chan_regs[{xfer_chan, 4'(OFS_ADDR_HI)}]  = xfer_addr[15:8];
                  chan_regs[{xfer_chan, 4'(OFS_COUNT_LO)}] = 8'h00;
                  chan_regs[{xfer_chan, 4'(OFS_COUNT_HI)}] = 8'h00;
                  pend_chans[xfer_chan] = 1'b0;
                  xfer_busy = 1'b0;
               end
               r.all_done = (pend_chans == '0) && !xfer_busy;
            end
         end
      endcase
   endtask

   // Channels whose byte count is small and nonzero, so that starting them ends quickly.
   function automatic logic [7:0] startable_channels();
      logic [7:0]  m;
      logic [15:0] n;
      m = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         n = {chan_regs[{3'(c), 4'(OFS_COUNT_HI)}], chan_regs[{3'(c), 4'(OFS_COUNT_LO)}]};
         m[c] = (n != 16'd0) && (n <= 16'd64);
      end
      return m;
   endfunction

   function automatic void add_row(input opcode_type op, input logic [7:0] addr, data, mask,
                                   input int unsigned reps = 1, input bit typed = 1'b0,
                                   input result_type want = '0);
      stim_row_type row;
      row.op = op;
      row.addr = addr;
      row.data = data;
      row.mask = mask;
      row.reps = reps;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   task automatic send_item(input opcode_type op, input logic [7:0] addr, data, mask,
                            input bit typed = 1'b0, input result_type want = '0);
      bit         produces;
      result_type predicted;
      if (!steady && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.reg_addr     <= addr;
      req_bus.write_data   <= data;
      req_bus.channel_mask <= mask;
      do @(posedge clock); while (!req_bus.ready);
      predict_dma(op, addr, data, mask, produces, predicted);
      if (produces) due_responses.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Sends every row of the table in order and empties it.
   task automatic walk_rows();
      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                      directed_rows[i].mask, directed_rows[i].typed, directed_rows[i].want);
         end
      end
      directed_rows.delete();
   endtask

   function automatic void check_field(input string name, input logic [23:0] want,
                                       input logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Response side: checks every accepted transaction and stalls in random bursts.
   initial begin
      result_type  want;
      int unsigned hold;
      int unsigned cycles;
      int unsigned stall_pct;
      hold = 0;
      cycles = 0;
      stall_pct = 10;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            responses_seen++;
            if (due_responses.size() == 0) begin
               $display("%0t: response with no transaction outstanding", $time);
               mismatches++;
            end else begin
               want = due_responses.pop_front();
               check_field("read_data", 24'(want.read_data), 24'(rsp_bus.read_data));
               check_field("xfer_valid", 24'(want.xfer_valid), 24'(rsp_bus.xfer_valid));
               check_field("a_bus_address", want.a_bus_address, rsp_bus.a_bus_address);
               check_field("b_bus_address", 24'(want.b_bus_address),
                           24'(rsp_bus.b_bus_address));
               check_field("to_memory", 24'(want.to_memory), 24'(rsp_bus.to_memory));
               check_field("channel_number", 24'(want.channel_number),
                           24'(rsp_bus.channel_number));
               check_field("channel_last", 24'(want.channel_last), 24'(rsp_bus.channel_last));
               check_field("all_done", 24'(want.all_done), 24'(rsp_bus.all_done));
            end
         end
         cycles++;
         if (cycles % 150 == 0) begin
            case ($urandom_range(2))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               default: stall_pct = 30;
            endcase
         end
         if (hold == 0 && !steady) begin
            // One long hold-off so that the block fills up and stalls its input.
            if (!pressure_done && responses_seen >= 300) begin
               hold = 80;
               pressure_done = 1'b1;
            end else if ($urandom_range(99) < stall_pct) begin
               hold = $urandom_range(1, 11);
            end
         end
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("general_dma_address_generator regression: fail");
      $finish;
   end

   // Request side: directed table, register initialization, random channel programs, then a zero-count run.
   initial begin
      result_type  quiet_done;
      int unsigned target;
      int unsigned pick;
      int unsigned count_max;
      bit          keep_addr;
      logic [7:0]  chans;
      logic [7:0]  a;
      logic [7:0]  d;
      logic [3:0]  live_ofs;

      foreach (chan_regs[i]) chan_regs[i] = 8'h00;
      pend_chans = '0;
      xfer_busy = 1'b0;
      xfer_chan = '0;
      xfer_addr = '0;
      xfer_left = '0;
      pat_phase = '0;
      items_sent = 0;
      responses_seen = 0;
      mismatches = 0;
      gap_pct = 20;
      steady = 1'b0;
      pressure_done = 1'b0;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_READ;
      req_bus.reg_addr     <= '0;
      req_bus.write_data   <= '0;
      req_bus.channel_mask <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      quiet_done = '0;
      quiet_done.all_done = 1'b1;

      // Idle tick and out-of-range accesses right after reset.
      add_row(OP_TICK,  8'h00, 8'h00, 8'h00, 1, 1'b1, quiet_done);
      add_row(OP_READ,  8'hFF, 8'h00, 8'h00, 1, 1'b1, quiet_done);
      add_row(OP_WRITE, 8'h80, 8'hFF, 8'h00);
      add_row(OP_READ,  8'h80, 8'h00, 8'h00, 1, 1'b1, quiet_done);
      // Channel 0: incrementing address from 0xFFFF, wrapping to 0x0000 within the bank.
      add_row(OP_WRITE, 8'h00 + 8'(OFS_PARAMS),   {3'b000, STEP_INC, PAT_PAIRS}, 8'h00);
      add_row(OP_WRITE, 8'h00 + 8'(OFS_BASE),     8'h80, 8'h00);
      add_row(OP_WRITE, 8'h00 + 8'(OFS_ADDR_LO),  8'hFF, 8'h00);
      add_row(OP_WRITE, 8'h00 + 8'(OFS_ADDR_HI),  8'hFF, 8'h00);
      add_row(OP_WRITE, 8'h00 + 8'(OFS_BANK),     8'h00, 8'h00);
      add_row(OP_WRITE, 8'h00 + 8'(OFS_COUNT_LO), 8'h03, 8'h00);
      add_row(OP_WRITE, 8'h00 + 8'(OFS_COUNT_HI), 8'h00, 8'h00);
      // Channel 7: to memory, decrementing through the bank wrap, base wraps at 8 bits.
      add_row(OP_WRITE, 8'h70 + 8'(OFS_PARAMS),   {3'b100, STEP_DEC, PAT_QUAD}, 8'h00);
      add_row(OP_WRITE, 8'h70 + 8'(OFS_BASE),     8'hFE, 8'h00);
      add_row(OP_WRITE, 8'h70 + 8'(OFS_ADDR_LO),  8'h01, 8'h00);
      add_row(OP_WRITE, 8'h70 + 8'(OFS_ADDR_HI),  8'h00, 8'h00);
      add_row(OP_WRITE, 8'h70 + 8'(OFS_BANK),     8'hFF, 8'h00);
      add_row(OP_WRITE, 8'h70 + 8'(OFS_COUNT_LO), 8'h05, 8'h00);
      add_row(OP_WRITE, 8'h70 + 8'(OFS_COUNT_HI), 8'h00, 8'h00);
      add_row(OP_READ,  8'h70 + 8'(OFS_BANK),     8'h00, 8'h00);
      add_row(OP_START, 8'h00, 8'h00, 8'h81);
      add_row(OP_TICK,  8'h00, 8'h00, 8'h00, 3 + 5);
      add_row(OP_READ,  8'h00 + 8'(OFS_ADDR_LO),  8'h00, 8'h00);
      add_row(OP_READ,  8'h70 + 8'(OFS_ADDR_HI),  8'h00, 8'h00);
      add_row(OP_READ,  8'h70 + 8'(OFS_COUNT_LO), 8'h00, 8'h00);
      add_row(OP_TICK,  8'hFF, 8'hFF, 8'hFF, 1, 1'b1, quiet_done);
      walk_rows();

      // Give every register byte a defined value before random reads and starts.
      for (int i = 0; i < REG_BYTES; i++) begin
         send_item(OP_WRITE, 8'(i), 8'($urandom()), 8'($urandom()));
      end

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         steady = (items_sent + 150 >= target);
         case ($urandom_range(2))
            0:       gap_pct = 0;
            1:       gap_pct = 12;
            default: gap_pct = 35;
         endcase
         chans = 8'($urandom()) & 8'($urandom());
         if (chans == '0) chans = 8'(1 << $urandom_range(NUM_CH - 1));
         for (int c = 0; c < NUM_CH; c++) begin
            if (chans[c]) begin
               keep_addr = ($urandom_range(3) == 0);
               count_max = ($urandom_range(3) == 0) ? 40 : 8;
               for (int o = OFS_PARAMS; o <= OFS_COUNT_HI; o++) begin
                  case (o)
                     OFS_COUNT_LO: d = 8'($urandom_range(1, count_max));
                     OFS_COUNT_HI: d = 8'h00;
                     default:      d = 8'($urandom());
                  endcase
                  if (!(keep_addr && (o == OFS_ADDR_LO || o == OFS_ADDR_HI))) begin
                     send_item(OP_WRITE, {1'b0, 3'(c), 4'(o)}, d, 8'($urandom()));
                  end
               end
            end
         end
         if ($urandom_range(3) == 0) chans |= startable_channels() & 8'($urandom());
         send_item(OP_START, 8'($urandom()), 8'($urandom()), chans);

         while (pend_chans != '0 || xfer_busy) begin
            pick = $urandom_range(99);
            a = 8'($urandom());
            d = 8'($urandom());
            if (pick < 70) begin
               send_item(OP_TICK, a, d, 8'($urandom()));
            end else if (pick < 80) begin
               send_item(OP_READ, a, d, 8'($urandom()));
            end else if (pick < 88) begin
               // Params, base and bank take effect on the very next transfer.
               case ($urandom_range(2))
                  0:       live_ofs = 4'(OFS_PARAMS);
                  1:       live_ofs = 4'(OFS_BASE);
                  default: live_ofs = 4'(OFS_BANK);
               endcase
               send_item(OP_WRITE, {1'b0, xfer_chan, live_ofs}, d, 8'($urandom()));
            end else if (pick < 95) begin
               // Keep any count that a write touches small and nonzero.
               if (a < REG_BYTES && a[3:0] == 4'(OFS_COUNT_LO)) d = 8'($urandom_range(1, 8));
               if (a < REG_BYTES && a[3:0] == 4'(OFS_COUNT_HI)) d = 8'h00;
               send_item(OP_WRITE, a, d, 8'($urandom()));
            end else begin
               send_item(OP_START, a, d, startable_channels() & 8'($urandom()));
            end
         end
         if ($urandom_range(2) == 0) begin
            send_item(OP_TICK, 8'($urandom()), 8'($urandom()), 8'($urandom()));
         end
      end

      // A zero count stands for 65536 bytes, so none of these transfers may be the last.
      steady = 1'b1;
      add_row(OP_WRITE, 8'h00 + 8'(OFS_COUNT_LO), 8'h00, 8'h00);
      add_row(OP_WRITE, 8'h00 + 8'(OFS_COUNT_HI), 8'h00, 8'h00);
      add_row(OP_START, 8'h00, 8'h00, 8'h01);
      add_row(OP_TICK,  8'h00, 8'h00, 8'h00, 20);
      add_row(OP_READ,  8'h00 + 8'(OFS_COUNT_LO), 8'h00, 8'h00);
      walk_rows();

      req_bus.valid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("general_dma_address_generator regression: pass");
      end else begin
         $display("general_dma_address_generator regression: fail");
      end
      $finish;
   end

endmodule
